FILE: rtl/assert_macros.svh
// Assertion macros used by keyboard_scancode_to_ascii.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on each rising edge of clk, disabled while rstn is low.
`define ASSERT_CLK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("%m: assertion failed");

`endif

FILE: rtl/kbd_s2a_pkg.sv
// Scancode constants and set-1 translation tables for the keyboard translator.
// No dependencies.
`default_nettype none

package kbd_s2a_pkg;

  localparam int unsigned ScanW  = 8;
  localparam int unsigned CodeW  = 7;
  localparam int unsigned AsciiW = 7;

  localparam logic [CodeW-1:0] CodeLCtrl  = 7'h1D;
  localparam logic [CodeW-1:0] CodeLShift = 7'h2A;
  localparam logic [CodeW-1:0] CodeLAlt   = 7'h38;
  localparam logic [CodeW-1:0] CodeCaps   = 7'h3A;

  localparam logic [AsciiW-1:0] ChDot   = 7'h2E;
  localparam logic [AsciiW-1:0] ChSpace = 7'h20;

  typedef struct packed {
    logic caps;
    logic shift;
    logic ctrl;
    logic alt;
  } mod_flags_t;

  function automatic logic [AsciiW-1:0] plain_char(input logic [CodeW-1:0] code);
    logic [AsciiW-1:0] ch;
    ch = ChDot;
    case (code)
      7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;  7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;  7'h09: ch = 7'h38;
      7'h0A: ch = 7'h39;  7'h0B: ch = 7'h30;  7'h0C: ch = 7'h2D;  7'h0D: ch = 7'h3D;
      7'h0E: ch = 7'h08;
      7'h10: ch = 7'h71;  7'h11: ch = 7'h77;  7'h12: ch = 7'h65;  7'h13: ch = 7'h72;
      7'h14: ch = 7'h74;  7'h15: ch = 7'h79;  7'h16: ch = 7'h75;  7'h17: ch = 7'h69;
      7'h18: ch = 7'h6F;  7'h19: ch = 7'h70;  7'h1A: ch = 7'h5B;  7'h1B: ch = 7'h5D;
      7'h1C: ch = 7'h0A;
      7'h1E: ch = 7'h61;  7'h1F: ch = 7'h73;  7'h20: ch = 7'h64;  7'h21: ch = 7'h66;
      7'h22: ch = 7'h67;  7'h23: ch = 7'h68;  7'h24: ch = 7'h6A;  7'h25: ch = 7'h6B;
      7'h26: ch = 7'h6C;  7'h27: ch = 7'h3B;  7'h28: ch = 7'h27;  7'h29: ch = 7'h60;
      7'h2B: ch = 7'h5C;
      7'h2C: ch = 7'h7A;  7'h2D: ch = 7'h78;  7'h2E: ch = 7'h63;  7'h2F: ch = 7'h76;
      7'h30: ch = 7'h62;  7'h31: ch = 7'h6E;  7'h32: ch = 7'h6D;  7'h33: ch = 7'h2C;
      7'h34: ch = 7'h2E;  7'h35: ch = 7'h2F;
      7'h37: ch = 7'h2A;  7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;  7'h48: ch = 7'h38;  7'h49: ch = 7'h39;  7'h4A: ch = 7'h2D;
      7'h4B: ch = 7'h34;  7'h4C: ch = 7'h35;  7'h4D: ch = 7'h36;  7'h4E: ch = 7'h2B;
      7'h4F: ch = 7'h31;  7'h50: ch = 7'h32;  7'h51: ch = 7'h33;  7'h52: ch = 7'h30;
      default: ch = ChDot;
    endcase
    return ch;
  endfunction

  function automatic logic [AsciiW-1:0] shifted_char(input logic [CodeW-1:0] code);
    logic [AsciiW-1:0] ch;
    ch = ChDot;
    case (code)
      7'h02: ch = 7'h21;  7'h03: ch = 7'h40;  7'h04: ch = 7'h23;  7'h05: ch = 7'h24;
      7'h06: ch = 7'h25;  7'h07: ch = 7'h5E;  7'h08: ch = 7'h26;  7'h09: ch = 7'h2A;
      7'h0A: ch = 7'h28;  7'h0B: ch = 7'h29;  7'h0C: ch = 7'h5F;  7'h0D: ch = 7'h2B;
      7'h0E: ch = 7'h08;
      7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;  7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;
      7'h18: ch = 7'h4F;  7'h19: ch = 7'h50;  7'h1A: ch = 7'h7B;  7'h1B: ch = 7'h7D;
      7'h1C: ch = 7'h0A;
      7'h1E: ch = 7'h41;  7'h1F: ch = 7'h53;  7'h20: ch = 7'h44;  7'h21: ch = 7'h46;
      7'h22: ch = 7'h47;  7'h23: ch = 7'h48;  7'h24: ch = 7'h4A;  7'h25: ch = 7'h4B;
      7'h26: ch = 7'h4C;  7'h27: ch = 7'h3A;  7'h28: ch = 7'h22;  7'h29: ch = 7'h7E;
      7'h2B: ch = 7'h7C;
      7'h2C: ch = 7'h5A;  7'h2D: ch = 7'h58;  7'h2E: ch = 7'h43;  7'h2F: ch = 7'h56;
      7'h30: ch = 7'h42;  7'h31: ch = 7'h4E;  7'h32: ch = 7'h4D;  7'h33: ch = 7'h3C;
      7'h34: ch = 7'h3E;  7'h35: ch = 7'h3F;
      7'h37: ch = 7'h2A;  7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;  7'h48: ch = 7'h38;  7'h49: ch = 7'h39;  7'h4A: ch = 7'h2D;
      7'h4B: ch = 7'h34;  7'h4C: ch = 7'h35;  7'h4D: ch = 7'h36;  7'h4E: ch = 7'h2B;
      7'h4F: ch = 7'h31;  7'h50: ch = 7'h32;  7'h51: ch = 7'h33;  7'h52: ch = 7'h30;
      default: ch = ChDot;
    endcase
    return ch;
  endfunction

  function automatic logic [AsciiW-1:0] upper_letter(input logic [AsciiW-1:0] ch);
    if (ch >= 7'h61 && ch <= 7'h7A) begin
      return ch - 7'h20;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/keyboard_scancode_to_ascii.sv
// Output: a character is registered and appears in the cycle after its scancode beat.
// Throughput: one scancode per cycle; the output register stalls input only
// while it holds an untaken character.
// Reset: modifier flags (caps, shift, ctrl, alt) and output valid clear.
// Depends on kbd_s2a_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module keyboard_scancode_to_ascii (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       scan_valid_i,
  output logic            scan_ready_o,
  input  wire logic [7:0] scan_byte_i,
  output logic            ascii_valid_o,
  input  wire logic       ascii_ready_i,
  output logic [6:0]      ascii_char_o
);

  kbd_s2a_pkg::mod_flags_t flags_q, flags_d;
  logic                    out_valid_q, out_valid_d;
  logic [6:0]              char_q, char_d;
  logic                    in_fire;
  logic                    is_release;
  logic [6:0]              code;
  logic                    gives_char;

  assign scan_ready_o  = !out_valid_q || ascii_ready_i;
  assign in_fire       = scan_valid_i && scan_ready_o;
  assign is_release    = scan_byte_i[7];
  assign code          = scan_byte_i[6:0];
  assign ascii_valid_o = out_valid_q;
  assign ascii_char_o  = char_q;

  assign gives_char = !is_release
                   && code != kbd_s2a_pkg::CodeLCtrl
                   && code != kbd_s2a_pkg::CodeLAlt
                   && code != kbd_s2a_pkg::CodeLShift
                   && code != kbd_s2a_pkg::CodeCaps;

  always_comb begin
    flags_d = flags_q;
    if (in_fire) begin
      if (is_release) begin
        if (code == kbd_s2a_pkg::CodeLCtrl)  flags_d.ctrl  = 1'b0;
        if (code == kbd_s2a_pkg::CodeLAlt)   flags_d.alt   = 1'b0;
        if (code == kbd_s2a_pkg::CodeLShift) flags_d.shift = 1'b0;
      end else begin
        if (code == kbd_s2a_pkg::CodeLCtrl)  flags_d.ctrl  = 1'b1;
        if (code == kbd_s2a_pkg::CodeLAlt)   flags_d.alt   = 1'b1;
        if (code == kbd_s2a_pkg::CodeLShift) flags_d.shift = 1'b1;
        if (code == kbd_s2a_pkg::CodeCaps)   flags_d.caps  = !flags_q.caps;
      end
    end
  end

  always_comb begin
    if (flags_q.shift) begin
      char_d = kbd_s2a_pkg::shifted_char(code);
    end else if (flags_q.ctrl || flags_q.alt) begin
      char_d = kbd_s2a_pkg::ChSpace;
    end else if (flags_q.caps) begin
      char_d = kbd_s2a_pkg::upper_letter(kbd_s2a_pkg::plain_char(code));
    end else begin
      char_d = kbd_s2a_pkg::plain_char(code);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !ascii_ready_i;
    if (in_fire && gives_char) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && gives_char) char_q <= char_d;
  end

  `ASSERT_CLK(caps_toggles_a, clk_i, rst_ni,
    in_fire && scan_byte_i == {1'b0, kbd_s2a_pkg::CodeCaps} |=> flags_q.caps != $past(flags_q.caps))
  `ASSERT_CLK(ctrl_press_sets_a, clk_i, rst_ni,
    in_fire && scan_byte_i == {1'b0, kbd_s2a_pkg::CodeLCtrl} |=> flags_q.ctrl)
  `ASSERT_CLK(release_no_char_a, clk_i, rst_ni,
    in_fire && is_release |=> out_valid_q == ($past(out_valid_q) && !$past(ascii_ready_i)))
  `ASSERT_CLK(ctrl_alt_space_a, clk_i, rst_ni,
    in_fire && gives_char && !flags_q.shift && (flags_q.ctrl || flags_q.alt)
      |=> ascii_valid_o && ascii_char_o == kbd_s2a_pkg::ChSpace)

endmodule

`default_nettype wire

FILE: tb/kbd_char_checker.sv
// Checker for the keyboard translator: watches both channels, tracks modifier state,
// predicts each character and compares it against the output beats.
// Depends on kbd_s2a_pkg for the modifier codes, flag struct and character constants.
module kbd_char_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       scan_valid_i,
  input  logic       scan_ready_i,
  input  logic [7:0] scan_byte_i,
  input  logic       ascii_valid_i,
  input  logic       ascii_ready_i,
  input  logic [6:0] ascii_char_i,
  output int         errors_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeyCount = 87;
  localparam logic [6:0] KeyBackspace = 7'h0E;
  localparam logic [6:0] KeyEnter = 7'h1C;
  localparam logic [6:0] CharBackspace = 7'h08;
  localparam logic [6:0] CharNewline = 7'h0A;

  // control keys are placeholders here; backspace and enter are patched in key_char
  localparam logic [8*KeyCount-1:0] PlainRow = {
    "..1234567890-=..qwertyuiop[].",
    ".asdfghjkl;'`.\\zxcvbnm,./.*. ",
    "..........", "...", "789-456+1230...."
  };
  localparam logic [8*KeyCount-1:0] ShiftRow = {
    "..!@#$%^&*()_+..QWERTYUIOP{}.",
    ".ASDFGHJKL:\"~.|ZXCVBNM<>?.*. ",
    "..........", "...", "789-456+1230...."
  };

  kbd_s2a_pkg::mod_flags_t mods;
  logic [6:0]  char_q[$];
  logic        has_char;
  logic [6:0]  next_char;
  logic [6:0]  want_char;
  int          err_cnt = 0;

  function automatic logic [6:0] key_char(input logic shifted, input logic [6:0] key);
    int idx;
    idx = KeyCount - 1 - int'(key);
    if (key >= KeyCount) begin
      return kbd_s2a_pkg::ChDot;
    end
    if (key == KeyBackspace) begin
      return CharBackspace;
    end
    if (key == KeyEnter) begin
      return CharNewline;
    end
    if (shifted) begin
      return ShiftRow[8*idx +: 7];
    end
    return PlainRow[8*idx +: 7];
  endfunction

  function automatic logic [6:0] upcase(input logic [6:0] ch);
    if (ch >= 7'h61 && ch <= 7'h7A) begin
      return ch - 7'h20;
    end
    return ch;
  endfunction

  task automatic translate_key(input logic [7:0] code, output logic hit,
                               output logic [6:0] ch);
    logic [6:0] key;
    key = code[6:0];
    hit = 1'b0;
    ch = '0;
    if (code[7]) begin
      if (key == kbd_s2a_pkg::CodeLCtrl) mods.ctrl = 1'b0;
      if (key == kbd_s2a_pkg::CodeLAlt) mods.alt = 1'b0;
      if (key == kbd_s2a_pkg::CodeLShift) mods.shift = 1'b0;
    end else if (key == kbd_s2a_pkg::CodeLCtrl) begin
      mods.ctrl = 1'b1;
    end else if (key == kbd_s2a_pkg::CodeLAlt) begin
      mods.alt = 1'b1;
    end else if (key == kbd_s2a_pkg::CodeLShift) begin
      mods.shift = 1'b1;
    end else if (key == kbd_s2a_pkg::CodeCaps) begin
      mods.caps = !mods.caps;
    end else begin
      hit = 1'b1;
      if (mods.shift) begin
        ch = key_char(1'b1, key);
        if (!mods.caps) ch = upcase(ch);
      end else if (mods.ctrl || mods.alt) begin
        ch = kbd_s2a_pkg::ChSpace;
      end else begin
        ch = key_char(1'b0, key);
        if (mods.caps) ch = upcase(ch);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mods = '0;
      char_q.delete();
      pending_o <= 0;
      errors_o <= err_cnt;
    end else begin
      // retire the output beat first: it belongs to an older scancode
      if (ascii_valid_i && ascii_ready_i) begin
        if (char_q.size() == 0) begin
          err_cnt++;
          $display("%0t: ascii_char expected none, actual %02h", $time, ascii_char_i);
        end else begin
          want_char = char_q.pop_front();
          if (ascii_char_i !== want_char) begin
            err_cnt++;
            $display("%0t: ascii_char expected %02h, actual %02h",
                     $time, want_char, ascii_char_i);
          end
        end
      end
      if (scan_valid_i && scan_ready_i) begin
        translate_key(scan_byte_i, has_char, next_char);
        if (has_char) char_q.push_back(next_char);
      end
      pending_o <= char_q.size();
      errors_o <= err_cnt;
    end
  end

endmodule

FILE: tb/keyboard_scancode_to_ascii_tb.sv
// Top of the keyboard translator testbench: clock, reset, scancode stimulus, output
// back-pressure and verdict. Depends on kbd_s2a_pkg, kbd_char_checker and the DUT.
module keyboard_scancode_to_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] RelBit = 8'h80;
  localparam logic [7:0] PressCaps = {1'b0, kbd_s2a_pkg::CodeCaps};
  localparam logic [7:0] PressShift = {1'b0, kbd_s2a_pkg::CodeLShift};
  localparam logic [7:0] PressCtrl = {1'b0, kbd_s2a_pkg::CodeLCtrl};
  localparam logic [7:0] PressAlt = {1'b0, kbd_s2a_pkg::CodeLAlt};
  localparam logic [7:0] ScanFirst = 8'h00;
  localparam logic [7:0] ScanOne = 8'h02;
  localparam logic [7:0] ScanBksp = 8'h0E;
  localparam logic [7:0] ScanQ = 8'h10;
  localparam logic [7:0] ScanP = 8'h19;
  localparam logic [7:0] ScanEnter = 8'h1C;
  localparam logic [7:0] ScanA = 8'h1E;
  localparam logic [7:0] ScanZ = 8'h2C;
  localparam logic [7:0] ScanRShift = 8'h36;
  localparam logic [7:0] ScanPadMinus = 8'h4A;
  localparam logic [7:0] ScanPadPlus = 8'h4E;
  localparam logic [7:0] ScanPadDot = 8'h53;
  localparam logic [7:0] ScanLastKey = 8'h56;
  localparam logic [7:0] ScanPastTable = 8'h57;
  localparam logic [7:0] ScanLastPress = 8'h7F;
  localparam int HoldCycles = 200;

  logic       clk;
  logic       rst_n;
  logic       scan_valid;
  logic       scan_ready;
  logic [7:0] scan_byte;
  logic       ascii_valid;
  logic       ascii_ready;
  logic [6:0] ascii_char;
  int         fail_count;
  int         pending_chars;
  bit         hold_req = 1'b0;
  bit         rx_eager = 1'b0;
  int         fed;
  logic [7:0] warmup_codes [0:26];

  keyboard_scancode_to_ascii dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .scan_valid_i  (scan_valid),
    .scan_ready_o  (scan_ready),
    .scan_byte_i   (scan_byte),
    .ascii_valid_o (ascii_valid),
    .ascii_ready_i (ascii_ready),
    .ascii_char_o  (ascii_char)
  );

  kbd_char_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .scan_valid_i  (scan_valid),
    .scan_ready_i  (scan_ready),
    .scan_byte_i   (scan_byte),
    .ascii_valid_i (ascii_valid),
    .ascii_ready_i (ascii_ready),
    .ascii_char_i  (ascii_char),
    .errors_o      (fail_count),
    .pending_o     (pending_chars)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** keyboard_scancode_to_ascii: FAILED **");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] random_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 8'($urandom_range(0, ScanLastKey));
    if (r < 62) begin
      case ($urandom_range(0, 3))
        0: return PressCaps;
        1: return PressShift;
        2: return PressCtrl;
        default: return PressAlt;
      endcase
    end
    if (r < 80) begin
      case ($urandom_range(0, 2))
        0: return PressShift | RelBit;
        1: return PressCtrl | RelBit;
        default: return PressAlt | RelBit;
      endcase
    end
    if (r < 88) return 8'($urandom_range(RelBit, 8'hFF));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_byte(input logic [7:0] code, input int gap);
    if (gap > 0) begin
      scan_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_valid <= 1'b1;
    scan_byte <= code;
    do @(posedge clk); while (!scan_ready);
  endtask

  task automatic drain();
    scan_valid <= 1'b0;
    do @(posedge clk); while (pending_chars != 0);
  endtask

  task automatic feed_random(input int upto, input bit no_gaps);
    logic [7:0] code;
    while (fed < upto) begin
      code = random_code();
      send_byte(code, no_gaps ? 0 : gap_len());
      fed++;
    end
  endtask

  initial begin : rx_side
    int n;
    ascii_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        ascii_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (rx_eager) begin
        ascii_ready <= 1'b1;
        @(posedge clk);
      end else begin
        ascii_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        n = gap_len();
        if (n > 0) begin
          ascii_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  initial begin
    warmup_codes = '{
      ScanFirst, ScanA, PressCaps, ScanA, PressCaps | RelBit, ScanQ,
      PressShift, ScanA, ScanOne, PressShift | RelBit, PressCaps,
      PressCtrl, ScanA, PressAlt, PressCtrl | RelBit, ScanZ, PressAlt | RelBit,
      ScanBksp, ScanEnter, ScanPadMinus, ScanPadPlus, ScanPadDot, ScanRShift,
      ScanPastTable, ScanLastPress, ScanLastPress | RelBit, ScanFirst | RelBit
    };
    rst_n <= 1'b0;
    scan_valid <= 1'b0;
    scan_byte <= '0;
    fed = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (warmup_codes[i]) send_byte(warmup_codes[i], gap_len());
    drain();

    // stall the output while streaming letters so the input backs up
    hold_req = 1'b1;
    wait (!hold_req);
    repeat (40) send_byte(8'($urandom_range(ScanQ, ScanP)), 0);
    drain();

    feed_random(500, 1'b0);
    drain();
    rx_eager = 1'b1;
    feed_random(800, 1'b1);
    drain();
    rx_eager = 1'b0;
    feed_random(1250, 1'b0);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** keyboard_scancode_to_ascii: PASSED **");
    end else begin
      $display("** keyboard_scancode_to_ascii: FAILED **");
    end
    $finish;
  end

endmodule
